[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/u8v_pkg.sv]
// ----------------------------------------------------------------------------
// u8v_pkg
// Types, constants and helper functions of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8v_pkg;

  // Width of the internal character counters
  localparam int CountWidth  = 32;
  // Fixed field widths
  localparam int TotalWidth  = 32;
  localparam int CodeWidth   = 21;
  localparam int ByteWidth   = 8;
  localparam int StatusWidth = 4;
  localparam int OutBits     = StatusWidth + CodeWidth + ByteWidth + 2 * TotalWidth;
  localparam int OutDataWidth = ((OutBits + 7) / 8) * 8;

  // Range limits of the decoded code point
  localparam logic [CodeWidth-1:0] MinTwoByte   = 21'h00080;
  localparam logic [CodeWidth-1:0] MinThreeByte = 21'h00800;
  localparam logic [CodeWidth-1:0] MinFourByte  = 21'h10000;
  localparam logic [CodeWidth-1:0] MaxCodePoint = 21'h10FFFF;
  localparam logic [CodeWidth-1:0] SurrogateLo  = 21'h0D800;
  localparam logic [CodeWidth-1:0] SurrogateHi  = 21'h0DFFF;

  // Sequence lengths
  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  typedef enum logic [StatusWidth-1:0] {
    ST_PENDING  = 4'd0,
    ST_ASCII    = 4'd1,
    ST_MULTI    = 4'd2,
    ST_INVALID  = 4'd3,
    ST_OVERLONG = 4'd4,
    ST_BAD_TAIL = 4'd5,
    ST_BAD_HEAD = 4'd6,
    ST_TRUNC    = 4'd7,
    ST_DONE     = 4'd8,
    ST_HALTED   = 4'd9
  } status_t;

  // One input item
  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 end_of_input;
  } item_t;

  // One result item
  typedef struct packed {
    status_t               status;
    logic [CodeWidth-1:0]  code_point;
    logic [ByteWidth-1:0]  offending_byte;
    logic [TotalWidth-1:0] ascii_total;
    logic [TotalWidth-1:0] multibyte_total;
  } result_t;

  // Counter increment that sticks at all ones
  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Report a counter clipped to the total field
  function automatic logic [TotalWidth-1:0] clip_total(input logic [CountWidth-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return (wide > 64'h0000_0000_FFFF_FFFF) ? '1 : wide[TotalWidth-1:0];
  endfunction

endpackage

[hdl/u8v_in_stage.sv]
// ----------------------------------------------------------------------------
// u8v_in_stage
// Input register: captures one item per cycle from the slave side while in_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8v_in_stage import u8v_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,       // downstream consumes the held item this cycle
  output logic  held_valid,
  output item_t held_item
);

  // Free when empty or when the held item leaves this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

[hdl/u8v_core.sv]
// ----------------------------------------------------------------------------
// u8v_core
// Decode and check of one byte against the open sequence, plus the
// sequence state and the two saturating character counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8v_core import u8v_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,     // held item is processed this cycle
  input  item_t   item,
  output result_t result
);

  logic                  halted, halted_next;
  logic [1:0]            bytes_left, bytes_left_next;
  logic [2:0]            seq_length, seq_length_next;
  logic [CodeWidth-1:0]  code_accum, code_accum_next;
  logic [CountWidth-1:0] ascii_count, ascii_count_next;
  logic [CountWidth-1:0] multibyte_count, multibyte_count_next;

  logic [ByteWidth-1:0]  b;
  logic [CodeWidth-1:0]  tail_accum;
  logic                  fail;
  status_t               status;
  logic [CodeWidth-1:0]  code_point;
  logic [ByteWidth-1:0]  offending_byte;

  assign b          = item.data_byte;
  assign tail_accum = {code_accum[CodeWidth-7:0], b[5:0]};

  // Next state and result of the current item
  always_comb begin
    halted_next          = halted;
    bytes_left_next      = bytes_left;
    seq_length_next      = seq_length;
    code_accum_next      = code_accum;
    ascii_count_next     = ascii_count;
    multibyte_count_next = multibyte_count;
    fail                 = 1'b0;
    status               = ST_PENDING;
    code_point           = '0;
    offending_byte       = '0;

    if (halted) begin
      status = ST_HALTED;
    end else if (item.end_of_input) begin
      if (bytes_left != 2'd0) begin
        status = ST_TRUNC;
        fail   = 1'b1;
      end else begin
        status = ST_DONE;
      end
    end else if (bytes_left == 2'd0) begin
      // header byte
      if (!b[7]) begin
        ascii_count_next = sat_inc(ascii_count);
        status           = ST_ASCII;
        code_point       = CodeWidth'(b);
      end else if (b[7:5] == 3'b110) begin
        code_accum_next = CodeWidth'(b[4:0]);
        bytes_left_next = 2'd1;
        seq_length_next = LenTwo;
      end else if (b[7:4] == 4'b1110) begin
        code_accum_next = CodeWidth'(b[3:0]);
        bytes_left_next = 2'd2;
        seq_length_next = LenThree;
      end else if (b[7:3] == 5'b11110) begin
        code_accum_next = CodeWidth'(b[2:0]);
        bytes_left_next = 2'd3;
        seq_length_next = LenFour;
      end else begin
        status         = ST_BAD_HEAD;
        offending_byte = b;
        fail           = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      status         = ST_BAD_TAIL;
      offending_byte = b;
      fail           = 1'b1;
    end else begin
      // tail byte
      code_accum_next = tail_accum;
      bytes_left_next = bytes_left - 2'd1;
      if (bytes_left == 2'd1) begin
        seq_length_next = LenNone;
        code_accum_next = '0;
        code_point      = tail_accum;
        status          = ST_MULTI;
        // overlong first, then range
        unique case (seq_length)
          LenTwo: begin
            if (tail_accum < MinTwoByte) status = ST_OVERLONG;
          end
          LenThree: begin
            if (tail_accum < MinThreeByte) status = ST_OVERLONG;
            else if (tail_accum >= SurrogateLo && tail_accum <= SurrogateHi)
              status = ST_INVALID;
          end
          default: begin
            if (tail_accum < MinFourByte) status = ST_OVERLONG;
            else if (tail_accum > MaxCodePoint) status = ST_INVALID;
          end
        endcase
        if (status == ST_MULTI) begin
          multibyte_count_next = sat_inc(multibyte_count);
        end else begin
          fail = 1'b1;
        end
      end
    end

    if (fail) begin
      halted_next     = 1'b1;
      bytes_left_next = 2'd0;
      seq_length_next = LenNone;
      code_accum_next = '0;
    end
  end

  assign result.status          = status;
  assign result.code_point      = code_point;
  assign result.offending_byte  = offending_byte;
  assign result.ascii_total     = clip_total(ascii_count_next);
  assign result.multibyte_total = clip_total(multibyte_count_next);

  // State update on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      halted          <= 1'b0;
      bytes_left      <= 2'd0;
      seq_length      <= LenNone;
      code_accum      <= '0;
      ascii_count     <= '0;
      multibyte_count <= '0;
    end else if (fire) begin
      halted          <= halted_next;
      bytes_left      <= bytes_left_next;
      seq_length      <= seq_length_next;
      code_accum      <= code_accum_next;
      ascii_count     <= ascii_count_next;
      multibyte_count <= multibyte_count_next;
    end
  end

endmodule

[hdl/u8v_out_stage.sv]
// ----------------------------------------------------------------------------
// u8v_out_stage
// Result register on the master side; packs the result into tdata.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8v_out_stage import u8v_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  output logic                    load_ready,
  input  result_t                 result,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OutDataWidth-1:0] m_tdata
);

  logic [OutDataWidth-1:0] packed_result;

  // Status in the lowest bits, zero fill on top
  assign packed_result = OutDataWidth'({result.multibyte_total, result.ascii_total,
                                        result.offending_byte, result.code_point,
                                        result.status});

  assign load_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= packed_result;
    end
  end

endmodule

[hdl/utf8_stream_validator.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Checks a UTF-8 byte stream and reports one result item per input item.
//
//   channel  dir  payload
//   s_*      in   tdata[7:0] data_byte, tlast end_of_input
//   m_*      out  tdata status/code_point/offending_byte/ascii_total/
//                 multibyte_total, 104 bits
//
// One item per cycle sustained while m_tready stays high; each accepted item
// passes the input register, then the result register.
// rst is synchronous and clears the sequence state, the counters, the halt
// flag and both valid flags.
// A stall on m_tready holds the result register and backs up into the
// input register; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_validator import u8v_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // [7:0] data_byte
  input  logic                    s_tlast,   // end_of_input
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OutDataWidth-1:0] m_tdata    // [3:0] status, [24:4] code_point,
                                             // [32:25] offending_byte,
                                             // [64:33] ascii_total,
                                             // [96:65] multibyte_total, rest 0
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    load_ready;
  logic    fire;
  result_t result;

  assign in_item.data_byte    = s_tdata;
  assign in_item.end_of_input = s_tlast;
  assign fire = held_valid && load_ready;

  u8v_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (load_ready),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  u8v_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held_item),
    .result (result)
  );

  u8v_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .load_ready (load_ready),
    .result     (result),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

[hdl/u8v_checker.sv]
// ----------------------------------------------------------------------------
// u8v_checker
// Port-level checks of the validator's result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8v_checker import u8v_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [OutDataWidth-1:0] m_tdata
);

  logic [StatusWidth-1:0] st;
  logic [CodeWidth-1:0]   cp;
  logic [ByteWidth-1:0]   ob;
  logic                   is_error;
  logic                   seen_error;
  logic                   stalled;
  logic                   late_valid;
  logic                   has_code;
  logic                   has_byte;

  assign st = m_tdata[StatusWidth-1:0];
  assign cp = m_tdata[24:4];
  assign ob = m_tdata[32:25];
  assign is_error = (st == ST_INVALID) || (st == ST_OVERLONG) || (st == ST_BAD_TAIL) ||
                    (st == ST_BAD_HEAD) || (st == ST_TRUNC);

  // Result item classes
  assign stalled    = m_tvalid && !m_tready;
  assign late_valid = m_tvalid && seen_error;
  assign has_code   = (st == ST_ASCII) || (st == ST_MULTI) || (st == ST_INVALID) ||
                      (st == ST_OVERLONG);
  assign has_byte   = (st == ST_BAD_TAIL) || (st == ST_BAD_HEAD);

  // Remember that an error result has gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_error <= 1'b0;
    end else if (m_tvalid && m_tready && is_error) begin
      seen_error <= 1'b1;
    end
  end

  // Stalled result holds
  `ASSERT_CLK(a_stall_hold, clk, rst, stalled |=> m_tvalid && $stable(m_tdata), "stall lost")

  // After an error, every result reports halted
  `ASSERT_CLK(a_halt_sticks, clk, rst, late_valid |-> st == ST_HALTED, "no halt after error")

  // Code bits only with a completed sequence, accepted or rejected
  `ASSERT_CLK(a_code_zero, clk, rst, m_tvalid && !has_code |-> cp == '0, "stray code point")

  // Offending byte only with a header or tail rejection
  `ASSERT_CLK(a_byte_zero, clk, rst, m_tvalid && !has_byte |-> ob == '0, "stray offending byte")

endmodule

bind utf8_stream_validator u8v_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
